### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked assertion that also holds across reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### hw/rtl/bcpa_pkg.sv
// Package for the bitmap contiguous page allocator: constants, codes and
// the structs passed between the controller, datapath and register block.
package bcpa_pkg;

    localparam int PAGES    = 4096;
    localparam int PAGE_W   = 12;
    localparam int CNT_W    = 13;
    localparam int ZONES    = 8;
    localparam int ZONE_W   = 3;
    localparam int ZIDX_W   = 4;
    localparam int MAX_RUN  = 64;
    localparam int RUN_W    = 7;
    localparam int K_W      = 6;
    localparam int ATTR_W   = 10;
    localparam int REF_W    = 16;
    localparam int LINK_W   = 32;

    // Request kinds
    localparam logic [1:0] REQ_DEFINE  = 2'd0;
    localparam logic [1:0] REQ_INIT    = 2'd1;
    localparam logic [1:0] REQ_ALLOC   = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // Zone classes
    localparam logic [1:0] CLS_DMA      = 2'd0;
    localparam logic [1:0] CLS_NORMAL   = 2'd1;
    localparam logic [1:0] CLS_UNMAPPED = 2'd2;
    localparam logic [1:0] CLS_INVALID  = 2'd3;

    // Result status
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_BADCLS = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_DMA_LAST   = 3'd0;
    localparam logic [2:0] REG_NORM_LAST  = 3'd1;
    localparam logic [2:0] REG_UNMAP_FST  = 3'd2;
    localparam logic [2:0] REG_ZONE_CNT   = 3'd3;
    localparam logic [2:0] REG_REF_MASK   = 3'd4;
    localparam logic [2:0] REG_SHR_MASK   = 3'd5;

    typedef struct packed {
        logic [ZONE_W-1:0] dma_last;
        logic [ZONE_W-1:0] normal_last;
        logic [ZONE_W-1:0] unmapped_first;
        logic [ZIDX_W-1:0] zone_count;
        logic [ATTR_W-1:0] ref_mask;
        logic [ATTR_W-1:0] shared_mask;
    } cfg_t;

    // One page entry of the page store
    typedef struct packed {
        logic              used;
        logic [ATTR_W-1:0] attr;
        logic [REF_W-1:0]  refs;
        logic [ZONE_W-1:0] zone;
    } page_row_t;

    typedef struct packed {
        logic       load_req;
        logic       clr_step;
        logic       def_start;
        logic       def_step;
        logic       rd_page;
        logic       init_wr;
        logic       alloc_start;
        logic       zone_enter;
        logic       zone_next;
        logic       scan_eval;
        logic       init_next;
        logic       set_res;
        logic [1:0] res_code;
        logic       res_alloc;
        logic       push;
    } dp_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic       p_lt_e;
        logic       zone_ok;
        logic       zone_fits;
        logic       hit;
        logic       k_last;
        logic       n_bad;
        logic [1:0] req_type;
        logic [1:0] cls;
        logic       out_free;
    } dp_sts_t;

endpackage

### hw/rtl/bcpa_cfg.sv
// APB register block for the allocator: zone ranges and flag masks.
// Depends on bcpa_pkg.
module bcpa_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output bcpa_pkg::cfg_t     cfg
);
    import bcpa_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_DMA_LAST:  cfg_next.dma_last       = pwdata[ZONE_W-1:0];
                REG_NORM_LAST: cfg_next.normal_last    = pwdata[ZONE_W-1:0];
                REG_UNMAP_FST: cfg_next.unmapped_first = pwdata[ZONE_W-1:0];
                REG_ZONE_CNT:  cfg_next.zone_count     = pwdata[ZIDX_W-1:0];
                REG_REF_MASK:  cfg_next.ref_mask       = pwdata[ATTR_W-1:0];
                REG_SHR_MASK:  cfg_next.shared_mask    = pwdata[ATTR_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{dma_last: '0, normal_last: '0, unmapped_first: '0,
                         zone_count: '0, ref_mask: ATTR_W'(4),
                         shared_mask: ATTR_W'(256)};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back
    always_comb begin
        case (idx)
            REG_DMA_LAST:  prdata = {29'd0, cfg_reg.dma_last};
            REG_NORM_LAST: prdata = {29'd0, cfg_reg.normal_last};
            REG_UNMAP_FST: prdata = {29'd0, cfg_reg.unmapped_first};
            REG_ZONE_CNT:  prdata = {28'd0, cfg_reg.zone_count};
            REG_REF_MASK:  prdata = {22'd0, cfg_reg.ref_mask};
            REG_SHR_MASK:  prdata = {22'd0, cfg_reg.shared_mask};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

### hw/rtl/bcpa_dp.sv
// Allocator datapath: page store, zone table, scan counters, result register.
// Depends on bcpa_pkg; driven by bcpa_ctrl through dp_cmd_t.
module bcpa_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bcpa_pkg::cfg_t       cfg,
    input  bcpa_pkg::dp_cmd_t    cmd,
    output bcpa_pkg::dp_sts_t    sts,
    input  logic [1:0]           s_req_type,
    input  logic [2:0]           s_zone_index,
    input  logic [11:0]          s_first_page,
    input  logic [12:0]          s_end_page,
    input  logic [1:0]           s_zone_class,
    input  logic [6:0]           s_page_count,
    input  logic [9:0]           s_page_flags,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [11:0]          m_start_page
);
    import bcpa_pkg::*;

    // Latched request
    logic [1:0]        req_reg, cls_reg;
    logic [ZONE_W-1:0] zi_reg;
    logic [PAGE_W-1:0] fp_reg;
    logic [CNT_W-1:0]  ep_reg;
    logic [RUN_W-1:0]  n_reg;
    logic [ATTR_W-1:0] flg_reg;

    // Walk state
    logic [CNT_W-1:0]  p_reg, e_reg;
    logic [RUN_W-1:0]  run_reg;
    logic [K_W-1:0]    k_reg;
    logic [ZIDX_W-1:0] z_reg;
    logic [PAGE_W-1:0] first_reg;

    // Result
    logic [1:0]        res_status_reg;
    logic [PAGE_W-1:0] res_start_reg;
    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [PAGE_W-1:0] m_start_reg;

    // Zone table
    logic [PAGE_W-1:0] zs_reg [ZONES];
    logic [CNT_W-1:0]  ze_reg [ZONES];
    logic [CNT_W-1:0]  zu_reg [ZONES];
    logic [CNT_W-1:0]  zf_reg [ZONES];
    logic [LINK_W-1:0] zl_reg [ZONES];

    // Page store
    page_row_t         mem [PAGES];
    page_row_t         rdata_reg;
    page_row_t         wrow;
    logic              we;

    logic [CNT_W-1:0]  def_end;
    logic [CNT_W-1:0]  p_inc, hit_first;
    logic [RUN_W-1:0]  run_inc;
    logic [ZIDX_W-1:0] z_begin, z_end;
    logic [ZONE_W-1:0] zsel;
    logic [ATTR_W-1:0] marks, a_or_f;
    logic              pg_unused, pg_marked;

    assign p_inc     = p_reg + CNT_W'(1);
    assign hit_first = p_inc - CNT_W'(n_reg);
    assign run_inc   = run_reg + RUN_W'(1);
    assign zsel      = z_reg[ZONE_W-1:0];
    assign def_end   = (ep_reg > CNT_W'(PAGES)) ? CNT_W'(PAGES) : ep_reg;

    // Search range of the selected class, end exclusive
    always_comb begin
        case (cls_reg)
            CLS_DMA: begin
                z_begin = '0;
                z_end   = ZIDX_W'(cfg.dma_last) + ZIDX_W'(1);
            end
            CLS_NORMAL: begin
                z_begin = ZIDX_W'(cfg.dma_last);
                z_end   = ZIDX_W'(cfg.normal_last) + ZIDX_W'(1);
            end
            default: begin
                z_begin = ZIDX_W'(cfg.unmapped_first);
                z_end   = cfg.zone_count;
            end
        endcase
    end

    // Page-init rule on the row just read
    assign marks     = cfg.ref_mask | cfg.shared_mask;
    assign a_or_f    = rdata_reg.attr | flg_reg;
    assign pg_unused = (rdata_reg.attr == '0);
    assign pg_marked = ((a_or_f & marks) != '0);

    // Write row select
    always_comb begin
        wrow = rdata_reg;
        we   = 1'b0;
        if (cmd.clr_step) begin
            we   = 1'b1;
            wrow = '{used: 1'b1, attr: '0, refs: '0, zone: '0};
        end else if (cmd.def_step) begin
            we   = 1'b1;
            wrow = '{used: 1'b0, attr: '0, refs: '0, zone: zi_reg};
        end else if (cmd.init_wr) begin
            we = 1'b1;
            if (pg_unused) begin
                wrow.used = 1'b1;
                wrow.attr = flg_reg;
                wrow.refs = rdata_reg.refs + REF_W'(1);
            end else if (pg_marked) begin
                wrow.attr = a_or_f;
                wrow.refs = rdata_reg.refs + REF_W'(1);
            end else begin
                wrow.used = 1'b1;
                wrow.attr = a_or_f;
            end
        end
    end

    // Page store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[p_reg[PAGE_W-1:0]] <= wrow;
        end
        if (cmd.rd_page) begin
            rdata_reg <= mem[p_reg[PAGE_W-1:0]];
        end
    end

    // Request latch
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_req_type;
            zi_reg  <= s_zone_index;
            fp_reg  <= s_first_page;
            ep_reg  <= s_end_page;
            cls_reg <= s_zone_class;
            n_reg   <= s_page_count;
            flg_reg <= s_page_flags;
        end
    end

    // Walk counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg <= '0;
        end else if (cmd.load_req) begin
            p_reg <= {1'b0, s_first_page};
        end else if (cmd.def_start) begin
            p_reg <= {1'b0, fp_reg};
        end else if (cmd.zone_enter) begin
            p_reg <= {1'b0, zs_reg[zsel]};
        end else if (cmd.scan_eval) begin
            p_reg <= sts.hit ? hit_first : p_inc;
        end else if (cmd.clr_step || cmd.def_step || cmd.init_next) begin
            p_reg <= p_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.def_start) begin
            e_reg <= def_end;
        end else if (cmd.zone_enter) begin
            e_reg <= ze_reg[zsel];
        end
        if (cmd.zone_enter) begin
            run_reg <= '0;
        end else if (cmd.scan_eval) begin
            run_reg <= rdata_reg.used ? '0 : run_inc;
        end
        if (cmd.scan_eval && sts.hit) begin
            first_reg <= hit_first[PAGE_W-1:0];
            k_reg     <= '0;
        end else if (cmd.init_next) begin
            k_reg <= k_reg + K_W'(1);
        end
        if (cmd.alloc_start) begin
            z_reg <= z_begin;
        end else if (cmd.zone_next) begin
            z_reg <= z_reg + ZIDX_W'(1);
        end
    end

    // Zone table updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ZONES; i++) begin
                zs_reg[i] <= '0;
                ze_reg[i] <= '0;
                zu_reg[i] <= '0;
                zf_reg[i] <= '0;
                zl_reg[i] <= '0;
            end
        end else if (cmd.def_start) begin
            zs_reg[zi_reg] <= fp_reg;
            ze_reg[zi_reg] <= def_end;
            zu_reg[zi_reg] <= '0;
            zl_reg[zi_reg] <= '0;
            zf_reg[zi_reg] <= (def_end > {1'b0, fp_reg}) ?
                              def_end - {1'b0, fp_reg} : '0;
        end else if (cmd.init_wr) begin
            if (pg_unused) begin
                zu_reg[rdata_reg.zone] <= zu_reg[rdata_reg.zone] + CNT_W'(1);
                zf_reg[rdata_reg.zone] <= zf_reg[rdata_reg.zone] - CNT_W'(1);
                zl_reg[rdata_reg.zone] <= zl_reg[rdata_reg.zone] + LINK_W'(1);
            end else if (pg_marked) begin
                zl_reg[rdata_reg.zone] <= zl_reg[rdata_reg.zone] + LINK_W'(1);
            end
        end
    end

    // Result staging and output register
    always_ff @(posedge aclk) begin
        if (cmd.set_res) begin
            res_status_reg <= cmd.res_code;
            res_start_reg  <= cmd.res_alloc ? first_reg : '0;
        end
        if (cmd.push) begin
            m_status_reg <= res_status_reg;
            m_start_reg  <= res_start_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_start_page = m_start_reg;

    // Status to the controller
    always_comb begin
        sts.clr_done  = (p_reg == CNT_W'(PAGES - 1));
        sts.p_lt_e    = (p_reg < e_reg);
        sts.zone_ok   = (z_reg < z_end) && (z_reg < ZIDX_W'(ZONES));
        sts.zone_fits = (zf_reg[zsel] >= CNT_W'(n_reg));
        sts.hit       = !rdata_reg.used && (run_inc == n_reg);
        sts.k_last    = (RUN_W'(k_reg) + RUN_W'(1) == n_reg);
        sts.n_bad     = (n_reg == '0) || (n_reg > RUN_W'(MAX_RUN));
        sts.req_type  = req_reg;
        sts.cls       = cls_reg;
        sts.out_free  = !m_valid_reg || m_ready;
    end

endmodule

### hw/rtl/bcpa_ctrl.sv
// Allocator controller: sequences clear, define, init and allocate steps.
// Depends on bcpa_pkg; commands bcpa_dp and reads its status.
module bcpa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bcpa_pkg::dp_sts_t  sts,
    output bcpa_pkg::dp_cmd_t  cmd
);
    import bcpa_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_DSET = 4'd3;
    localparam logic [3:0] S_DEF  = 4'd4;
    localparam logic [3:0] S_IRD  = 4'd5;
    localparam logic [3:0] S_IWR  = 4'd6;
    localparam logic [3:0] S_ASET = 4'd7;
    localparam logic [3:0] S_ZCHK = 4'd8;
    localparam logic [3:0] S_SRD  = 4'd9;
    localparam logic [3:0] S_SEV  = 4'd10;
    localparam logic [3:0] S_PRD  = 4'd11;
    localparam logic [3:0] S_PWR  = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [3:0] state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            // Sweep the page store to its reset contents
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DISP;
                end
            end
            S_DISP: begin
                case (sts.req_type)
                    REQ_DEFINE: state_next = S_DSET;
                    REQ_INIT:   state_next = S_IRD;
                    REQ_ALLOC: begin
                        if (sts.cls == CLS_INVALID) begin
                            cmd.set_res  = 1'b1;
                            cmd.res_code = ST_BADCLS;
                            state_next   = S_DONE;
                        end else begin
                            state_next = S_ASET;
                        end
                    end
                    default: begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = ST_OK;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_DSET: begin
                cmd.def_start = 1'b1;
                state_next    = S_DEF;
            end
            S_DEF: begin
                if (sts.p_lt_e) begin
                    cmd.def_step = 1'b1;
                end else begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_OK;
                    state_next   = S_DONE;
                end
            end
            S_IRD: begin
                cmd.rd_page = 1'b1;
                state_next  = S_IWR;
            end
            S_IWR: begin
                cmd.init_wr  = 1'b1;
                cmd.set_res  = 1'b1;
                cmd.res_code = ST_OK;
                state_next   = S_DONE;
            end
            S_ASET: begin
                if (sts.n_bad) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_NOFIT;
                    state_next   = S_DONE;
                end else begin
                    cmd.alloc_start = 1'b1;
                    state_next      = S_ZCHK;
                end
            end
            // Next zone of the class, skipping ones short of free pages
            S_ZCHK: begin
                if (!sts.zone_ok) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_NOFIT;
                    state_next   = S_DONE;
                end else if (!sts.zone_fits) begin
                    cmd.zone_next = 1'b1;
                end else begin
                    cmd.zone_enter = 1'b1;
                    state_next     = S_SRD;
                end
            end
            S_SRD: begin
                if (sts.p_lt_e) begin
                    cmd.rd_page = 1'b1;
                    state_next  = S_SEV;
                end else begin
                    cmd.zone_next = 1'b1;
                    state_next    = S_ZCHK;
                end
            end
            S_SEV: begin
                cmd.scan_eval = 1'b1;
                state_next    = sts.hit ? S_PRD : S_SRD;
            end
            // Apply page init over the found run
            S_PRD: begin
                cmd.rd_page = 1'b1;
                state_next  = S_PWR;
            end
            S_PWR: begin
                cmd.init_wr   = 1'b1;
                cmd.init_next = 1'b1;
                if (sts.k_last) begin
                    cmd.set_res   = 1'b1;
                    cmd.res_code  = ST_OK;
                    cmd.res_alloc = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    state_next = S_PRD;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/bitmap_contiguous_page_allocator.sv
// Bitmap first-fit contiguous page allocator, top level.
// Depends on bcpa_pkg, bcpa_cfg, bcpa_ctrl and bcpa_dp.
//
// Requests arrive on the s_ valid/ready channel and each gives exactly one
// result transfer on the m_ channel (status, start_page). Zone ranges and
// flag masks sit in APB registers at byte addresses 0,4,..,20; write them
// only while the block is idle.
// After reset the page store is swept to its reset contents, one page a
// cycle: s_ready stays low until the sweep ends (configuration writes
// still go through). One request is worked on at a time, in these steps:
//   define zone : a setup step, then one write per page of the range
//   init page   : a read of the page, then its write
//   allocate    : a setup step, a check per zone visited, a read and an
//                 evaluate per page scanned, a read and a write per
//                 allocated page
//   other       : straight to the result
// The result then goes into the output register. A result held by a stalled
// receiver waits in that register while the next request is accepted and
// worked on; its completion then waits until the register is free.
module bitmap_contiguous_page_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [2:0]  s_zone_index,
    input  logic [11:0] s_first_page,
    input  logic [12:0] s_end_page,
    input  logic [1:0]  s_zone_class,
    input  logic [6:0]  s_page_count,
    input  logic [9:0]  s_page_flags,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [11:0] m_start_page,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bcpa_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    bcpa_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bcpa_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts),
        .s_req_type   (s_req_type),
        .s_zone_index (s_zone_index),
        .s_first_page (s_first_page),
        .s_end_page   (s_end_page),
        .s_zone_class (s_zone_class),
        .s_page_count (s_page_count),
        .s_page_flags (s_page_flags),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_start_page (m_start_page)
    );

endmodule

### hw/rtl/bcpa_chk.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on assert_macros.svh and bcpa_pkg.
`include "assert_macros.svh"

module bcpa_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [11:0] m_start_page,
    input logic        pready
);
    import bcpa_pkg::*;

    // The store is swept after every reset before requests are taken
    `ASSERT_ALWAYS(a_clr_after_rst, !aresetn |=> !s_ready, "request taken during clear")

    // A stalled result holds
    `ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_start_page), "result changed under stall")

    // Failed requests report start page zero
    `ASSERT_CLK(a_fail_zero, m_valid && m_status != ST_OK |-> m_start_page == '0, "start page set on failure")

    // Only defined status codes
    `ASSERT_CLK(a_status_code, m_valid |-> m_status <= ST_BADCLS, "undefined status code")

    `ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind bitmap_contiguous_page_allocator bcpa_chk u_bcpa_chk (.*);
